/* sv/assert_macros.svh */
// Assertion macros shared by the sorted key/value list RTL.
// Each macro takes a label, clock, active-low reset, property terms and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define SKV_ASSERT(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the clock cycle after the antecedent.
`define SKV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/skv_pkg.sv */
// Package for the sorted key/value list: sizes, operation and status codes,
// and the command type that steers each storage cell. No dependencies.
`default_nettype none

package skv_pkg;

    localparam int CAPACITY  = 16;
    localparam int DATA_BITS = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int TDATA_W   = ((2 * DATA_BITS + 7) / 8) * 8;

    typedef logic signed [DATA_BITS-1:0] t_data;

    localparam logic [1:0] OP_INSERT    = 2'd0;
    localparam logic [1:0] OP_REMOVE    = 2'd1;
    localparam logic [1:0] OP_LIST_ASC  = 2'd2;
    localparam logic [1:0] OP_LIST_DESC = 2'd3;

    localparam logic [2:0] STAT_INSERTED  = 3'd0;
    localparam logic [2:0] STAT_DUPLICATE = 3'd1;
    localparam logic [2:0] STAT_REMOVED   = 3'd2;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [2:0] STAT_FULL      = 3'd4;
    localparam logic [2:0] STAT_ENTRY     = 3'd5;
    localparam logic [2:0] STAT_EMPTY     = 3'd6;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_NEW,
        CELL_LEFT,
        CELL_RIGHT
    } t_cell_cmd;

endpackage

`default_nettype wire

/* sv/skv_cell.sv */
// One storage cell of the sorted chain: holds a key/value pair and loads
// new data or a neighbor's pair on command. Depends on skv_pkg.
`default_nettype none

module skv_cell
    import skv_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_cmd i_cmd,
    input  wire t_data     i_new_key,
    input  wire t_data     i_new_val,
    input  wire t_data     i_left_key,
    input  wire t_data     i_left_val,
    input  wire t_data     i_right_key,
    input  wire t_data     i_right_val,
    output t_data          o_key,
    output t_data          o_val
);

    t_data r_key, r_val;
    t_data n_key, n_val;

    always_comb begin
        unique case (i_cmd)
            CELL_HOLD: begin
                n_key = r_key;
                n_val = r_val;
            end
            CELL_NEW: begin
                n_key = i_new_key;
                n_val = i_new_val;
            end
            CELL_LEFT: begin
                n_key = i_left_key;
                n_val = i_left_val;
            end
            CELL_RIGHT: begin
                n_key = i_right_key;
                n_val = i_right_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_val <= n_val;
    end

    assign o_key = r_key;
    assign o_val = r_val;

endmodule

`default_nettype wire

/* sv/sorted_key_value_list.sv */
// Sorted key/value list: a row of cells kept in ascending signed key order.
// Insert, remove and the two listing operations are steered from here.
// Depends on skv_pkg, skv_cell and assert_macros.svh.
//
// Usage: commands arrive on the s_axis channel, tuser carrying the operation
// and tdata the key and value. Results leave on the m_axis channel, tuser
// carrying the status, tdata the key and value, tlast the final beat of a
// command. Insert and remove compare the key against every cell at once and
// shift the row in the accepting cycle; their single result is registered
// and shown in the next cycle, so they run at one command per cycle while
// the receiver keeps up. A listing rotates the row one cell per beat and
// emits one beat per stored entry; the next command is taken once the last
// entry's beat is loaded. An empty listing gives one beat of empty status.
// The output register decouples the sides: a stalled receiver holds the
// current beat, and a new command or listing step is taken once that beat
// leaves. Reset empties the list and the output; the cells are not cleared.
`default_nettype none

module sorted_key_value_list
    import skv_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire logic [TDATA_W-1:0] i_s_axis_tdata,  // key, value
    input  wire logic [1:0]         i_s_axis_tuser,  // operation
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    output logic [TDATA_W-1:0]      o_m_axis_tdata,  // out_key, out_value
    output logic [2:0]              o_m_axis_tuser,  // status
    output logic                    o_m_axis_tlast   // last
);

    `include "assert_macros.svh"

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LIST = 1'b1;

    logic             r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_desc, n_desc;
    logic             r_ovalid, n_ovalid;
    logic [2:0]       r_ostat, n_ostat;
    t_data            r_okey, n_okey;
    t_data            r_oval, n_oval;
    logic             r_olast, n_olast;

    t_data            w_in_key, w_in_val;
    logic [1:0]       w_op;
    logic             w_load_ok, w_in_acc, w_full, w_any_hit, w_list_last;
    t_data            w_hit_val, w_new_key, w_new_val, w_tail_key, w_tail_val;
    logic [CNT_W-1:0] w_cnt_m1;

    t_cell_cmd        w_cmd   [CAPACITY];
    t_data            w_key   [CAPACITY];
    t_data            w_val   [CAPACITY];
    logic [CAPACITY-1:0] w_lt, w_eq, w_prev_lt;

    assign w_in_key  = t_data'(i_s_axis_tdata[DATA_BITS-1:0]);
    assign w_in_val  = t_data'(i_s_axis_tdata[2*DATA_BITS-1:DATA_BITS]);
    assign w_op      = i_s_axis_tuser;
    assign w_load_ok = !r_ovalid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && w_load_ok;
    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign w_cnt_m1  = r_count - CNT_W'(1);
    assign w_tail_key = w_key[w_cnt_m1[IDX_W-1:0]];
    assign w_tail_val = w_val[w_cnt_m1[IDX_W-1:0]];
    assign w_list_last = (r_idx == w_cnt_m1);

    assign w_any_hit = |w_eq;
    always_comb begin
        w_hit_val = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_hit_val = w_hit_val | (w_eq[i] ? w_val[i] : t_data'(0));
        end
    end

    always_comb begin
        if (r_state == ST_IDLE) begin
            w_new_key = w_in_key;
            w_new_val = w_in_val;
        end else if (r_desc) begin
            w_new_key = w_tail_key;
            w_new_val = w_tail_val;
        end else begin
            w_new_key = w_key[0];
            w_new_val = w_val[0];
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_data w_left_key, w_left_val, w_right_key, w_right_val;
        logic  w_valid;

        if (g == 0) begin : g_first
            assign w_left_key   = w_key[g];
            assign w_left_val   = w_val[g];
            assign w_prev_lt[g] = 1'b1;
        end else begin : g_inner
            assign w_left_key   = w_key[g-1];
            assign w_left_val   = w_val[g-1];
            assign w_prev_lt[g] = w_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_key = w_key[g];
            assign w_right_val = w_val[g];
        end else begin : g_body
            assign w_right_key = w_key[g+1];
            assign w_right_val = w_val[g+1];
        end

        assign w_valid = (CNT_W'(g) < r_count);
        assign w_lt[g] = w_valid && (w_key[g] < w_in_key);
        assign w_eq[g] = w_valid && (w_key[g] == w_in_key);

        always_comb begin
            w_cmd[g] = CELL_HOLD;
            if (w_in_acc) begin
                if (w_op == OP_INSERT && !w_any_hit && !w_full && !w_lt[g]) begin
                    w_cmd[g] = w_prev_lt[g] ? CELL_NEW : CELL_LEFT;
                end else if (w_op == OP_REMOVE && w_any_hit && !w_lt[g] &&
                             g != CAPACITY - 1) begin
                    w_cmd[g] = CELL_RIGHT;
                end
            end else if (r_state == ST_LIST && w_load_ok) begin
                if (r_desc) begin
                    if (g == 0) begin
                        w_cmd[g] = CELL_NEW;
                    end else if (w_valid) begin
                        w_cmd[g] = CELL_LEFT;
                    end
                end else begin
                    if (CNT_W'(g) == w_cnt_m1) begin
                        w_cmd[g] = CELL_NEW;
                    end else if (CNT_W'(g) < w_cnt_m1) begin
                        w_cmd[g] = CELL_RIGHT;
                    end
                end
            end
        end

        skv_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd[g]),
            .i_new_key   (w_new_key),
            .i_new_val   (w_new_val),
            .i_left_key  (w_left_key),
            .i_left_val  (w_left_val),
            .i_right_key (w_right_key),
            .i_right_val (w_right_val),
            .o_key       (w_key[g]),
            .o_val       (w_val[g])
        );
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_desc   = r_desc;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        n_ostat  = r_ostat;
        n_okey   = r_okey;
        n_oval   = r_oval;
        n_olast  = r_olast;
        if (w_in_acc) begin
            n_olast = 1'b1;
            n_okey  = '0;
            n_oval  = '0;
            unique case (w_op)
                OP_INSERT: begin
                    n_ovalid = 1'b1;
                    if (w_any_hit) begin
                        n_ostat = STAT_DUPLICATE;
                        n_okey  = w_in_key;
                        n_oval  = w_hit_val;
                    end else if (w_full) begin
                        n_ostat = STAT_FULL;
                    end else begin
                        n_ostat = STAT_INSERTED;
                        n_okey  = w_in_key;
                        n_oval  = w_in_val;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                OP_REMOVE: begin
                    n_ovalid = 1'b1;
                    if (w_any_hit) begin
                        n_ostat = STAT_REMOVED;
                        n_okey  = w_in_key;
                        n_oval  = w_hit_val;
                        n_count = w_cnt_m1;
                    end else begin
                        n_ostat = STAT_NOT_FOUND;
                    end
                end
                OP_LIST_ASC, OP_LIST_DESC: begin
                    if (r_count == '0) begin
                        n_ovalid = 1'b1;
                        n_ostat  = STAT_EMPTY;
                    end else begin
                        n_state = ST_LIST;
                        n_idx   = '0;
                        n_desc  = (w_op == OP_LIST_DESC);
                    end
                end
            endcase
        end else if (r_state == ST_LIST && w_load_ok) begin
            n_ovalid = 1'b1;
            n_ostat  = STAT_ENTRY;
            n_okey   = w_new_key;
            n_oval   = w_new_val;
            n_olast  = w_list_last;
            n_idx    = r_idx + CNT_W'(1);
            if (w_list_last) begin
                n_state = ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_desc   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_desc   <= n_desc;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ostat <= n_ostat;
        r_okey  <= n_okey;
        r_oval  <= n_oval;
        r_olast <= n_olast;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tuser  = r_ostat;
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tdata  = TDATA_W'({r_oval, r_okey});

    `SKV_ASSERT(a_count_bound, i_clk, i_rst_n,
        r_count <= CNT_W'(CAPACITY), "count above capacity")
    `SKV_ASSERT(a_list_nonempty, i_clk, i_rst_n,
        r_state != ST_LIST || r_count != '0, "listing an empty list")
    `SKV_ASSERT_NEXT(a_list_count_stable, i_clk, i_rst_n, r_state == ST_LIST,
        r_count == $past(r_count), "count changed while listing")

endmodule

`default_nettype wire
